// File: sv/tiled_texture_address_generator_defines.svh
// ---------------------------------------------------------------------------
// Tiled texture address generator: assertion macros
// Shared concurrent assertion helpers, compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef TILED_TEXTURE_ADDRESS_GENERATOR_DEFINES_SVH
`define TILED_TEXTURE_ADDRESS_GENERATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a consequent in the same cycle as its antecedent
`define TTAG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Check a consequent in the cycle after its antecedent
`define TTAG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TTAG_ASSERT_NOW(lbl, ante, cons, msg)
`define TTAG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/ttag_pkg.sv
// ---------------------------------------------------------------------------
// Tiled texture address generator package
// Widths, register indexes, transfer structs and helper functions.
// ---------------------------------------------------------------------------
package ttag_pkg;

    // Field widths
    localparam int OFFSET_W    = 40;
    localparam int EDGE_W      = 15;
    localparam int COORD_W     = 14;
    localparam int FACE_W      = 4;
    localparam int MIP_W       = 4;
    localparam int FACES_W     = 5;
    localparam int BPB_W       = 5;
    localparam int SHIFT_W     = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;

    // Tiling geometry: 8x8 blocks per tile
    localparam int TILE_SHIFT  = 3;
    localparam int MORTON_W    = 2 * TILE_SHIFT;
    localparam int TPR_W       = EDGE_W - TILE_SHIFT;
    localparam int TROW_W      = COORD_W - TILE_SHIFT;
    localparam int TILE_IDX_W  = TPR_W + TROW_W;
    localparam int LOCAL_W     = TILE_IDX_W + MORTON_W;
    localparam int AREA_W      = 2 * EDGE_W;
    localparam int LOCAL_B_W   = LOCAL_W + BPB_W;
    localparam int MIP_B_W     = AREA_W + BPB_W;
    localparam int ROUND_W     = EDGE_W + 1;

    // Saturation limits
    localparam int MAX_EDGE    = 16384;
    localparam int MAX_FACES   = 16;
    localparam int MAX_BPB     = 16;
    localparam int MAX_SHIFT   = 2;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH      = 3'd0,
        REG_IMAGE_HEIGHT     = 3'd1,
        REG_MIP_COUNT        = 3'd2,
        REG_FACE_COUNT       = 3'd3,
        REG_BYTES_PER_BLOCK  = 3'd4,
        REG_BLOCK_EDGE_SHIFT = 3'd5
    } cfg_index_t;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [EDGE_W-1:0]  width;
        logic [EDGE_W-1:0]  height;
        logic [MIP_W-1:0]   mips;
        logic [FACES_W-1:0] faces;
        logic [BPB_W-1:0]   bpb;
        logic [SHIFT_W-1:0] shift;
    } cfg_t;

    // Per-block fields that travel down the offset pipeline
    typedef struct packed {
        logic [OFFSET_W-1:0] linear_offset;
        logic [FACE_W-1:0]   face_index;
        logic [MIP_W-1:0]    mip_level;
        logic [COORD_W-1:0]  block_x;
        logic [COORD_W-1:0]  block_y;
        logic [BPB_W-1:0]    bpb;
        logic                start;
        logic                end_mip;
        logic                last;
    } meta_t;

    // Walker output: block fields plus the mip's block extent
    typedef struct packed {
        meta_t             meta;
        logic [EDGE_W-1:0] blocks_wide;
        logic [EDGE_W-1:0] blocks_high;
    } walk_item_t;

    // Pixel count to block count, rounded up, at least one
    function automatic logic [EDGE_W-1:0] blocks_of(input logic [EDGE_W-1:0] pixels,
                                                    input logic [SHIFT_W-1:0] shift);
        logic [ROUND_W-1:0] rounded;
        logic [ROUND_W-1:0] blocks;
        rounded = {1'b0, pixels} + (ROUND_W'(1) << shift) - ROUND_W'(1);
        blocks  = rounded >> shift;
        if (blocks == '0) begin
            blocks = ROUND_W'(1);
        end
        return blocks[EDGE_W-1:0];
    endfunction

    // Halve a mip edge with a floor of one pixel
    function automatic logic [EDGE_W-1:0] halve_edge(input logic [EDGE_W-1:0] pixels);
        logic [EDGE_W-1:0] half;
        half = pixels >> 1;
        if (half == '0) begin
            half = EDGE_W'(1);
        end
        return half;
    endfunction

    // Round a block count up to a whole tile
    function automatic logic [EDGE_W-1:0] pad_tile(input logic [EDGE_W-1:0] blocks);
        logic [EDGE_W-1:0] tile_mask;
        tile_mask = EDGE_W'((1 << TILE_SHIFT) - 1);
        return (blocks + tile_mask) & ~tile_mask;
    endfunction

endpackage

// File: sv/ttag_cfg_regs.sv
// ---------------------------------------------------------------------------
// Configuration registers
// Holds the job registers and presents their saturated effective values.
// ---------------------------------------------------------------------------
module ttag_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ttag_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ttag_pkg::CFG_DATA_W-1:0]    cfg_data,
    output ttag_pkg::cfg_t                     cfg
);

    logic [ttag_pkg::EDGE_W-1:0]  width_reg;
    logic [ttag_pkg::EDGE_W-1:0]  height_reg;
    logic [ttag_pkg::MIP_W-1:0]   mips_reg;
    logic [ttag_pkg::FACES_W-1:0] faces_reg;
    logic [ttag_pkg::BPB_W-1:0]   bpb_reg;
    logic [ttag_pkg::SHIFT_W-1:0] shift_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= ttag_pkg::EDGE_W'(1);
            height_reg <= ttag_pkg::EDGE_W'(1);
            mips_reg   <= ttag_pkg::MIP_W'(1);
            faces_reg  <= ttag_pkg::FACES_W'(1);
            bpb_reg    <= ttag_pkg::BPB_W'(4);
            shift_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ttag_pkg::REG_IMAGE_WIDTH:      width_reg  <= cfg_data[ttag_pkg::EDGE_W-1:0];
                ttag_pkg::REG_IMAGE_HEIGHT:     height_reg <= cfg_data[ttag_pkg::EDGE_W-1:0];
                ttag_pkg::REG_MIP_COUNT:        mips_reg   <= cfg_data[ttag_pkg::MIP_W-1:0];
                ttag_pkg::REG_FACE_COUNT:       faces_reg  <= cfg_data[ttag_pkg::FACES_W-1:0];
                ttag_pkg::REG_BYTES_PER_BLOCK:  bpb_reg    <= cfg_data[ttag_pkg::BPB_W-1:0];
                ttag_pkg::REG_BLOCK_EDGE_SHIFT: shift_reg  <= cfg_data[ttag_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate: zero reads as one (a zero shift stays zero), oversize reads as the limit
    always_comb begin
        cfg.width = width_reg;
        if (width_reg == '0) begin
            cfg.width = ttag_pkg::EDGE_W'(1);
        end else if (width_reg > ttag_pkg::EDGE_W'(ttag_pkg::MAX_EDGE)) begin
            cfg.width = ttag_pkg::EDGE_W'(ttag_pkg::MAX_EDGE);
        end

        cfg.height = height_reg;
        if (height_reg == '0) begin
            cfg.height = ttag_pkg::EDGE_W'(1);
        end else if (height_reg > ttag_pkg::EDGE_W'(ttag_pkg::MAX_EDGE)) begin
            cfg.height = ttag_pkg::EDGE_W'(ttag_pkg::MAX_EDGE);
        end

        cfg.mips = (mips_reg == '0) ? ttag_pkg::MIP_W'(1) : mips_reg;

        cfg.faces = faces_reg;
        if (faces_reg == '0) begin
            cfg.faces = ttag_pkg::FACES_W'(1);
        end else if (faces_reg > ttag_pkg::FACES_W'(ttag_pkg::MAX_FACES)) begin
            cfg.faces = ttag_pkg::FACES_W'(ttag_pkg::MAX_FACES);
        end

        cfg.bpb = bpb_reg;
        if (bpb_reg == '0) begin
            cfg.bpb = ttag_pkg::BPB_W'(1);
        end else if (bpb_reg > ttag_pkg::BPB_W'(ttag_pkg::MAX_BPB)) begin
            cfg.bpb = ttag_pkg::BPB_W'(ttag_pkg::MAX_BPB);
        end

        cfg.shift = (shift_reg > ttag_pkg::SHIFT_W'(ttag_pkg::MAX_SHIFT)) ?
                    ttag_pkg::SHIFT_W'(ttag_pkg::MAX_SHIFT) : shift_reg;
    end

endmodule

// File: sv/ttag_walker.sv
// ---------------------------------------------------------------------------
// Block walker
// Steps face, mip, row and column counters and the linear offset once per
// accepted input transfer, and registers the current block for the pipeline.
// ---------------------------------------------------------------------------
module ttag_walker (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ttag_pkg::cfg_t         cfg,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_restart,
    output logic                   item_valid,
    input  logic                   item_ready,
    output ttag_pkg::walk_item_t   item
);

    logic [ttag_pkg::FACE_W-1:0]   face_reg, face_next;
    logic [ttag_pkg::MIP_W-1:0]    mip_reg, mip_next;
    logic [ttag_pkg::EDGE_W-1:0]   mw_reg, mw_next;
    logic [ttag_pkg::EDGE_W-1:0]   mh_reg, mh_next;
    logic [ttag_pkg::EDGE_W-1:0]   bw_reg, bw_next;
    logic [ttag_pkg::EDGE_W-1:0]   bh_reg, bh_next;
    logic [ttag_pkg::COORD_W-1:0]  col_reg, col_next;
    logic [ttag_pkg::COORD_W-1:0]  row_reg, row_next;
    logic [ttag_pkg::OFFSET_W-1:0] lin_reg, lin_next;
    logic                          active_reg, active_next;
    logic                          item_valid_reg;
    ttag_pkg::walk_item_t          item_reg, item_next;

    logic                          accept;
    logic                          start;
    logic [ttag_pkg::FACE_W-1:0]   cur_face;
    logic [ttag_pkg::MIP_W-1:0]    cur_mip;
    logic [ttag_pkg::EDGE_W-1:0]   cur_mw, cur_mh, cur_bw, cur_bh;
    logic [ttag_pkg::EDGE_W-1:0]   half_w, half_h;
    logic [ttag_pkg::COORD_W-1:0]  cur_col, cur_row;
    logic [ttag_pkg::OFFSET_W-1:0] cur_lin;
    logic                          end_row, end_mip, more_mips, more_faces, last;

    // Take a new item whenever the stage register is free or draining
    assign s_ready    = !item_valid_reg || item_ready;
    assign accept     = s_valid && s_ready;
    assign item_valid = item_valid_reg;
    assign item       = item_reg;

    // Current position, with restart or idle start folded in
    always_comb begin
        start    = s_restart || !active_reg;
        cur_face = start ? '0 : face_reg;
        cur_mip  = start ? '0 : mip_reg;
        cur_mw   = start ? cfg.width  : mw_reg;
        cur_mh   = start ? cfg.height : mh_reg;
        cur_bw   = start ? ttag_pkg::blocks_of(cfg.width,  cfg.shift) : bw_reg;
        cur_bh   = start ? ttag_pkg::blocks_of(cfg.height, cfg.shift) : bh_reg;
        cur_col  = start ? '0 : col_reg;
        cur_row  = start ? '0 : row_reg;
        cur_lin  = start ? '0 : lin_reg;
    end

    // Advance the walk
    always_comb begin
        end_row    = ({1'b0, cur_col} + ttag_pkg::EDGE_W'(1)) >= cur_bw;
        end_mip    = end_row && (({1'b0, cur_row} + ttag_pkg::EDGE_W'(1)) >= cur_bh);
        more_mips  = ({1'b0, cur_mip} + ttag_pkg::FACES_W'(1)) < {1'b0, cfg.mips};
        more_faces = ({1'b0, cur_face} + ttag_pkg::FACES_W'(1)) < cfg.faces;
        half_w     = ttag_pkg::halve_edge(cur_mw);
        half_h     = ttag_pkg::halve_edge(cur_mh);

        face_next   = cur_face;
        mip_next    = cur_mip;
        mw_next     = cur_mw;
        mh_next     = cur_mh;
        bw_next     = cur_bw;
        bh_next     = cur_bh;
        col_next    = cur_col;
        row_next    = cur_row;
        active_next = 1'b1;
        last        = 1'b0;
        lin_next    = cur_lin + ttag_pkg::OFFSET_W'(cfg.bpb);

        if (!end_row) begin
            col_next = cur_col + ttag_pkg::COORD_W'(1);
        end else if (!end_mip) begin
            col_next = '0;
            row_next = cur_row + ttag_pkg::COORD_W'(1);
        end else if (more_mips) begin
            mip_next = cur_mip + ttag_pkg::MIP_W'(1);
            mw_next  = half_w;
            mh_next  = half_h;
            bw_next  = ttag_pkg::blocks_of(half_w, cfg.shift);
            bh_next  = ttag_pkg::blocks_of(half_h, cfg.shift);
            col_next = '0;
            row_next = '0;
        end else if (more_faces) begin
            face_next = cur_face + ttag_pkg::FACE_W'(1);
            mip_next  = '0;
            mw_next   = cfg.width;
            mh_next   = cfg.height;
            bw_next   = ttag_pkg::blocks_of(cfg.width,  cfg.shift);
            bh_next   = ttag_pkg::blocks_of(cfg.height, cfg.shift);
            col_next  = '0;
            row_next  = '0;
        end else begin
            last        = 1'b1;
            active_next = 1'b0;
        end

        item_next.meta.linear_offset = cur_lin;
        item_next.meta.face_index    = cur_face;
        item_next.meta.mip_level     = cur_mip;
        item_next.meta.block_x       = cur_col;
        item_next.meta.block_y       = cur_row;
        item_next.meta.bpb           = cfg.bpb;
        item_next.meta.start         = start;
        item_next.meta.end_mip       = end_mip;
        item_next.meta.last          = last;
        item_next.blocks_wide        = cur_bw;
        item_next.blocks_high        = cur_bh;
    end

    // Walk state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_reg   <= '0;
            mip_reg    <= '0;
            mw_reg     <= ttag_pkg::EDGE_W'(1);
            mh_reg     <= ttag_pkg::EDGE_W'(1);
            bw_reg     <= ttag_pkg::EDGE_W'(1);
            bh_reg     <= ttag_pkg::EDGE_W'(1);
            col_reg    <= '0;
            row_reg    <= '0;
            lin_reg    <= '0;
            active_reg <= 1'b0;
        end else if (accept) begin
            face_reg   <= face_next;
            mip_reg    <= mip_next;
            mw_reg     <= mw_next;
            mh_reg     <= mh_next;
            bw_reg     <= bw_next;
            bh_reg     <= bh_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            lin_reg    <= lin_next;
            active_reg <= active_next;
        end
    end

    // Stage register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (accept) begin
            item_valid_reg <= 1'b1;
        end else if (item_ready) begin
            item_valid_reg <= 1'b0;
        end
    end

    // Stage register payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

// File: sv/ttag_offset_pipe.sv
// ---------------------------------------------------------------------------
// Tiled offset pipeline
// Three elastic stages: tile index and mip area, byte scaling, then the
// running mip base add into the output register.
// ---------------------------------------------------------------------------
module ttag_offset_pipe (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  ttag_pkg::walk_item_t                item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ttag_pkg::OFFSET_W-1:0]       m_linear_offset,
    output logic [ttag_pkg::OFFSET_W-1:0]       m_tiled_offset,
    output logic [ttag_pkg::FACE_W-1:0]         m_face_index,
    output logic [ttag_pkg::MIP_W-1:0]          m_mip_level,
    output logic [ttag_pkg::COORD_W-1:0]        m_block_x,
    output logic [ttag_pkg::COORD_W-1:0]        m_block_y,
    output logic                                m_last
);

    // Stage A: tile index and padded mip area
    logic                                s2_valid_reg;
    ttag_pkg::meta_t                     s2_meta_reg;
    logic [ttag_pkg::LOCAL_W-1:0]        s2_local_reg, s2_local_next;
    logic [ttag_pkg::AREA_W-1:0]         s2_area_reg, s2_area_next;

    // Stage B: byte scaling
    logic                                s3_valid_reg;
    ttag_pkg::meta_t                     s3_meta_reg;
    logic [ttag_pkg::LOCAL_B_W-1:0]      s3_local_b_reg, s3_local_b_next;
    logic [ttag_pkg::MIP_B_W-1:0]        s3_mip_b_reg, s3_mip_b_next;

    // Output stage
    logic                                out_valid_reg;
    logic [ttag_pkg::OFFSET_W-1:0]       base_reg, base_next;
    logic [ttag_pkg::OFFSET_W-1:0]       tiled_next;
    logic [ttag_pkg::OFFSET_W-1:0]       lin_out_reg;
    logic [ttag_pkg::OFFSET_W-1:0]       tiled_out_reg;
    logic [ttag_pkg::FACE_W-1:0]         face_out_reg;
    logic [ttag_pkg::MIP_W-1:0]          mip_out_reg;
    logic [ttag_pkg::COORD_W-1:0]        bx_out_reg;
    logic [ttag_pkg::COORD_W-1:0]        by_out_reg;
    logic                                last_out_reg;

    logic                                s2_ready, s3_ready, out_ready;
    logic [ttag_pkg::EDGE_W-1:0]         pad_w, pad_h;
    logic [ttag_pkg::TPR_W-1:0]          tiles_per_row;
    logic [ttag_pkg::TROW_W-1:0]         tile_row, tile_col;
    logic [ttag_pkg::TILE_IDX_W-1:0]     tile_idx;
    logic [ttag_pkg::MORTON_W-1:0]       morton;
    logic [ttag_pkg::OFFSET_W-1:0]       base_eff;

    // Ready chain: a stage loads when empty or when its successor loads
    assign out_ready  = !out_valid_reg || m_ready;
    assign s3_ready   = !s3_valid_reg || out_ready;
    assign s2_ready   = !s2_valid_reg || s3_ready;
    assign item_ready = s2_ready;

    // Stage A logic: tile coordinates, in-tile Morton code, mip area
    always_comb begin
        pad_w         = ttag_pkg::pad_tile(item.blocks_wide);
        pad_h         = ttag_pkg::pad_tile(item.blocks_high);
        tiles_per_row = pad_w[ttag_pkg::EDGE_W-1:ttag_pkg::TILE_SHIFT];
        tile_row      = item.meta.block_y[ttag_pkg::COORD_W-1:ttag_pkg::TILE_SHIFT];
        tile_col      = item.meta.block_x[ttag_pkg::COORD_W-1:ttag_pkg::TILE_SHIFT];
        tile_idx      = ttag_pkg::TILE_IDX_W'(tile_row) * ttag_pkg::TILE_IDX_W'(tiles_per_row)
                      + ttag_pkg::TILE_IDX_W'(tile_col);
        morton        = {item.meta.block_y[2], item.meta.block_x[2],
                         item.meta.block_y[1], item.meta.block_x[1],
                         item.meta.block_y[0], item.meta.block_x[0]};
        s2_local_next = {tile_idx, morton};
        s2_area_next  = ttag_pkg::AREA_W'(pad_w) * ttag_pkg::AREA_W'(pad_h);
    end

    // Stage B logic: scale block counts to bytes
    always_comb begin
        s3_local_b_next = ttag_pkg::LOCAL_B_W'(s2_local_reg)
                        * ttag_pkg::LOCAL_B_W'(s2_meta_reg.bpb);
        s3_mip_b_next   = ttag_pkg::MIP_B_W'(s2_area_reg)
                        * ttag_pkg::MIP_B_W'(s2_meta_reg.bpb);
    end

    // Output logic: add the mip base, advance it at the end of a mip
    always_comb begin
        base_eff   = s3_meta_reg.start ? '0 : base_reg;
        tiled_next = base_eff + ttag_pkg::OFFSET_W'(s3_local_b_reg);
        base_next  = base_eff;
        if (s3_meta_reg.end_mip) begin
            base_next = base_eff + ttag_pkg::OFFSET_W'(s3_mip_b_reg);
        end
    end

    // Stage valids and running base
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
        end else begin
            if (s2_ready) begin
                s2_valid_reg <= item_valid;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= s3_valid_reg;
                if (s3_valid_reg) begin
                    base_reg <= base_next;
                end
            end
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (s2_ready && item_valid) begin
            s2_meta_reg  <= item.meta;
            s2_local_reg <= s2_local_next;
            s2_area_reg  <= s2_area_next;
        end
        if (s3_ready && s2_valid_reg) begin
            s3_meta_reg    <= s2_meta_reg;
            s3_local_b_reg <= s3_local_b_next;
            s3_mip_b_reg   <= s3_mip_b_next;
        end
        if (out_ready && s3_valid_reg) begin
            lin_out_reg   <= s3_meta_reg.linear_offset;
            tiled_out_reg <= tiled_next;
            face_out_reg  <= s3_meta_reg.face_index;
            mip_out_reg   <= s3_meta_reg.mip_level;
            bx_out_reg    <= s3_meta_reg.block_x;
            by_out_reg    <= s3_meta_reg.block_y;
            last_out_reg  <= s3_meta_reg.last;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_linear_offset = lin_out_reg;
    assign m_tiled_offset  = tiled_out_reg;
    assign m_face_index    = face_out_reg;
    assign m_mip_level     = mip_out_reg;
    assign m_block_x       = bx_out_reg;
    assign m_block_y       = by_out_reg;
    assign m_last          = last_out_reg;

endmodule

// File: sv/tiled_texture_address_generator.sv
// ---------------------------------------------------------------------------
// Tiled texture address generator
// Walks every block of a texture job (face, mip, row, column) and gives the
// block's row-major and 8x8 Morton-tiled byte offsets.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready, s_restart): each transfer asks for the
//   next block; s_restart high, or a transfer after the last block, starts
//   the walk again at face 0, mip 0, block 0.
//   Result channel (m_valid/m_ready): one result per input transfer, in
//   order, with m_last high on the final block of the job.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   write only while no block is in flight.
//   An input transfer passes the walker's stage register and three registered
//   offset stages (tile index, byte scale, mip base add) before m_valid;
//   throughput is one block per cycle while the receiver takes results.
//   When the receiver stalls, the stages fill and s_ready drops once all
//   four registers hold a block; nothing is lost or repeated.
//   Reset clears the walk to idle, empties the pipeline and restores the
//   registers to 1x1, one mip, one face, 4 bytes per block.
// ---------------------------------------------------------------------------
`include "tiled_texture_address_generator_defines.svh"

module tiled_texture_address_generator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ttag_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ttag_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_restart,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ttag_pkg::OFFSET_W-1:0]      m_linear_offset,
    output logic [ttag_pkg::OFFSET_W-1:0]      m_tiled_offset,
    output logic [ttag_pkg::FACE_W-1:0]        m_face_index,
    output logic [ttag_pkg::MIP_W-1:0]         m_mip_level,
    output logic [ttag_pkg::COORD_W-1:0]       m_block_x,
    output logic [ttag_pkg::COORD_W-1:0]       m_block_y,
    output logic                               m_last
);

    ttag_pkg::cfg_t        cfg;
    ttag_pkg::walk_item_t  item;
    logic                  item_valid;
    logic                  item_ready;
    logic                  start_at_origin;

    // Configuration registers
    ttag_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Counter walk and linear offset
    ttag_walker u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_restart  (s_restart),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // Tiled offset stages and result register
    ttag_offset_pipe u_offset_pipe (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .item            (item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_linear_offset (m_linear_offset),
        .m_tiled_offset  (m_tiled_offset),
        .m_face_index    (m_face_index),
        .m_mip_level     (m_mip_level),
        .m_block_x       (m_block_x),
        .m_block_y       (m_block_y),
        .m_last          (m_last)
    );

    // Stage block sits at face 0, mip 0, block 0 with a zero linear offset
    assign start_at_origin = (item.meta.face_index == '0) && (item.meta.mip_level == '0)
                          && (item.meta.block_x == '0) && (item.meta.block_y == '0)
                          && (item.meta.linear_offset == '0);

    // A ready receiver must open the whole ready chain back to the input
    `TTAG_ASSERT_NOW(a_ready_chain, m_ready, s_ready, "ready chain blocked with m_ready high")

    // A walk start always describes the first block of the job
    `TTAG_ASSERT_NOW(a_start_origin, item_valid && item.meta.start, start_at_origin, "walk start not at origin")

    // An input transfer lands in the walker stage register
    `TTAG_ASSERT_NEXT(a_accept_lands, s_valid && s_ready, item_valid, "accepted transfer missing from stage")

endmodule
